### rtl/assert_macros.svh
// Assertion macros used by the checker file sha256_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is low.
`define SHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/sha256_pkg.sv
// Shared types, constants and tables of the SHA-256 engine.
`default_nettype none
package sha256_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FINISH = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_INIT,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_P80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] PRE_LEN_FILL = 6'd55;

  typedef struct packed {
    logic        push;
    byte_sel_t   sel;
    logic        cnt_inc;
    logic        load;
    logic        round;
    logic [5:0]  rnd;
    logic        add;
    logic        restart;
    logic [2:0]  idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_status_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0: round_k = 32'h428a2f98;  6'd1: round_k = 32'h71374491;
      6'd2: round_k = 32'hb5c0fbcf;  6'd3: round_k = 32'he9b5dba5;
      6'd4: round_k = 32'h3956c25b;  6'd5: round_k = 32'h59f111f1;
      6'd6: round_k = 32'h923f82a4;  6'd7: round_k = 32'hab1c5ed5;
      6'd8: round_k = 32'hd807aa98;  6'd9: round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage
`default_nettype wire

### rtl/sha256_ctrl.sv
// Control state machine of the SHA-256 engine: input, padding, rounds, output.
`default_nettype none
module sha256_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [1:0]             opcode,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire sha256_pkg::dp_status_t stat,
  output sha256_pkg::ctl_cmd_t        cmd
);
  import sha256_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;
  logic       p80_r, p80_nxt;
  logic       lenph_r, lenph_nxt;
  logic       done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      p80_r   <= 1'b0;
      lenph_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      p80_r   <= p80_nxt;
      lenph_r <= lenph_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    fin_nxt    = fin_r;
    p80_nxt    = p80_r;
    lenph_nxt  = lenph_r;
    done_nxt   = done_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    cmd.sel    = SEL_MSG;
    cmd.rnd    = rnd_r;
    cmd.idx    = idx_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (opcode)
            OP_APPEND, OP_FINISH: begin
              cmd.push    = 1'b1;
              cmd.cnt_inc = 1'b1;
              fin_nxt     = (opcode == OP_FINISH);
              if (stat.fill == LAST_FILL) begin
                state_nxt = S_INIT;
              end else if (opcode == OP_FINISH) begin
                state_nxt = S_PAD;
              end
            end
            OP_FLUSH: begin
              fin_nxt   = 1'b1;
              state_nxt = S_PAD;
            end
            default: ;
          endcase
        end
      end
      S_PAD: begin
        // One padding byte per cycle: the marker, zeros, then the bit length.
        cmd.push = 1'b1;
        if (!p80_r) begin
          cmd.sel = SEL_P80;
          p80_nxt = 1'b1;
          if (stat.fill == PRE_LEN_FILL) lenph_nxt = 1'b1;
        end else if (lenph_r) begin
          cmd.sel = SEL_LEN;
          if (stat.fill == LAST_FILL) done_nxt = 1'b1;
        end else begin
          cmd.sel = SEL_ZERO;
          if (stat.fill == PRE_LEN_FILL) lenph_nxt = 1'b1;
        end
        if (stat.fill == LAST_FILL) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.load  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == LAST_FILL) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (done_r) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else if (fin_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.restart = 1'b1;
            fin_nxt     = 1'b0;
            p80_nxt     = 1'b0;
            lenph_nxt   = 1'b0;
            done_nxt    = 1'b0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/sha256_dp.sv
// Datapath of the SHA-256 engine: block shift register, schedule, rounds, hash.
`default_nettype none
module sha256_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           msg_byte,
  input  wire sha256_pkg::ctl_cmd_t cmd,
  output sha256_pkg::dp_status_t    stat,
  output logic [31:0]               digest_word
);
  import sha256_pkg::*;

  // The block buffer doubles as the message schedule window: word 0 is the
  // oldest, the top 32 bits.
  logic [511:0] blk_r;
  logic [31:0]  hash_r [8];
  logic [31:0]  wk_r   [8];
  logic [63:0]  cnt_r;
  logic [5:0]   fill_r;

  logic [63:0] bits;
  logic [7:0]  len_byte, push_byte;
  logic [31:0] w0, w1, w9, w14, w_new, s0w, s1w;
  logic [31:0] bs0, bs1, ch, maj, t1, t2;

  assign bits     = {cnt_r[60:0], 3'b000};
  assign len_byte = 8'(bits >> {~fill_r[2:0], 3'b000});

  always_comb begin
    case (cmd.sel)
      SEL_MSG:  push_byte = msg_byte;
      SEL_P80:  push_byte = PAD_MARK;
      SEL_LEN:  push_byte = len_byte;
      default:  push_byte = 8'h00;
    endcase
  end

  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign s0w = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign s1w = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign w_new = s1w + w9 + s0w + w0;

  assign bs1 = {wk_r[4][5:0], wk_r[4][31:6]} ^ {wk_r[4][10:0], wk_r[4][31:11]}
             ^ {wk_r[4][24:0], wk_r[4][31:25]};
  assign ch  = (wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]);
  assign t1  = wk_r[7] + bs1 + ch + round_k(cmd.rnd) + w0;
  assign bs0 = {wk_r[0][1:0], wk_r[0][31:2]} ^ {wk_r[0][12:0], wk_r[0][31:13]}
             ^ {wk_r[0][21:0], wk_r[0][31:22]};
  assign maj = (wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]);
  assign t2  = bs0 + maj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fill_r <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= init_hash(3'(i));
    end else begin
      if (cmd.push) fill_r <= fill_r + 6'd1;
      if (cmd.cnt_inc) cnt_r <= cnt_r + 64'd1;
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + wk_r[i];
      end
      if (cmd.restart) begin
        cnt_r <= '0;
        for (int i = 0; i < 8; i++) hash_r[i] <= init_hash(3'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk_r <= {blk_r[503:0], push_byte};
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], w_new};
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) wk_r[i] <= hash_r[i];
    end else if (cmd.round) begin
      wk_r[7] <= wk_r[6];
      wk_r[6] <= wk_r[5];
      wk_r[5] <= wk_r[4];
      wk_r[4] <= wk_r[3] + t1;
      wk_r[3] <= wk_r[2];
      wk_r[2] <= wk_r[1];
      wk_r[1] <= wk_r[0];
      wk_r[0] <= t1 + t2;
    end
  end

  assign stat.fill   = fill_r;
  assign digest_word = hash_r[cmd.idx];
endmodule
`default_nettype wire

### rtl/sha256_hash_engine_top.sv
// SHA-256 engine: one input beat per byte, eight output beats per digest.
// A full block adds a load, 64 rounds on one shared round unit and a hash update.
// Finishing pads one byte per cycle between blocks (9 to 72 bytes, one or two
// blocks), then gives one digest word per cycle while out_tready is high.
// rst_n is synchronous and active low; reset loads the initial hash values
// and clears the byte count and fill level.
`default_nettype none
module sha256_hash_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] message_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast
);
  import sha256_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t stat;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .opcode     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .msg_byte    (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (out_tdata)
  );

  assign out_tuser = cmd.idx;
  assign out_tlast = (cmd.idx == 3'd7);
endmodule
`default_nettype wire

### rtl/sha256_chk.sv
// Port-level checker of the SHA-256 engine and its bind.
`default_nettype none
`include "assert_macros.svh"
module sha256_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);
  // No input beat is taken while a digest is being delivered.
  `SHA_ASSERT_NOW(a_no_in_during_out, clk, rst_n, out_tvalid, !in_tready)
  // The last beat of a digest carries the top word index.
  `SHA_ASSERT_NOW(a_last_index, clk, rst_n, out_tvalid && out_tlast, out_tuser == 3'd7)
  // After the final word the engine is ready for the next message.
  `SHA_ASSERT_NEXT(a_ready_after, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready)
  // A stalled output beat holds its word.
  `SHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind sha256_hash_engine_top sha256_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### bench/sha256_hash_engine_top_tb.sv
// Self-checking bench for the SHA-256 hash engine with a scoreboard and random stream stalls.
`default_nettype none
module sha256_hash_engine_top_tb;
  import sha256_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  class digest_scoreboard;
    logic [31:0] hash [8];
    logic [7:0]  block [64];
    logic [63:0] byte_total;
    int          fill;
    digest_beat_t pending [$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hash[i] = init_ref(i);
      byte_total = '0;
      fill = 0;
    endfunction

    function logic [31:0] init_ref(int i);
      logic [31:0] iv [8];
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return iv[i];
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] k [64];
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
        end else begin
          w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
                 (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
      end
      {a, b, c, d, e, f, g, h} = {hash[0], hash[1], hash[2], hash[3],
                                  hash[4], hash[5], hash[6], hash[7]};
      for (int t = 0; t < 64; t++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k[t] + w[t];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash[0] += a; hash[1] += b; hash[2] += c; hash[3] += d;
      hash[4] += e; hash[5] += f; hash[6] += g; hash[7] += h;
    endfunction

    function void push(logic [7:0] v);
      block[fill] = v;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] data);
      logic [63:0] bits;
      digest_beat_t beat;
      if (op == OP_IGNORED) return;
      if (op != OP_FLUSH) begin
        push(data);
        byte_total++;
      end
      if (op == OP_APPEND) return;
      bits = byte_total << 3;
      push(PAD_MARK);
      while (fill != 56) push(8'h00);
      for (int i = 7; i >= 0; i--) push(bits[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        beat.word = hash[i];
        beat.index = i[2:0];
        beat.last = (i == 7);
        pending.push_back(beat);
      end
      restart();
    endfunction

    function void check_result(logic [31:0] word, logic [2:0] index, logic last);
      digest_beat_t exp_beat;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected beat word=%h index=%0d", word, index));
        return;
      end
      exp_beat = pending.pop_front();
      if (word !== exp_beat.word)
        report_mismatch($sformatf("word %0d: got %h want %h", exp_beat.index, word, exp_beat.word));
      if (index !== exp_beat.index)
        report_mismatch($sformatf("index: got %0d want %0d", index, exp_beat.index));
      if (last !== exp_beat.last)
        report_mismatch($sformatf("last on word %0d: got %b want %b", exp_beat.index, last,
                                  exp_beat.last));
    endfunction

    function void report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  digest_scoreboard board;
  int idle_cycles;

  sha256_hash_engine_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_length();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Holds one beat on the input channel until the engine takes it. The ready
  // flag is sampled on the falling edge before the rising edge, so that it is the
  // value the engine sees at that edge.
  task automatic send_item(logic [1:0] op, logic [7:0] data);
    int gap;
    bit taken;
    gap = gap_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    board.note_input(op, data);
  endtask

  task automatic send_message(int len, bit with_flush);
    for (int i = 0; i < len; i++) begin
      if (!with_flush && i == len - 1) send_item(OP_FINISH, 8'($urandom));
      else send_item(OP_APPEND, 8'($urandom));
    end
    if (with_flush || len == 0) send_item(OP_FLUSH, 8'($urandom));
  endtask

  // Random backpressure on the result channel.
  initial begin
    int hold;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(9) == 0) hold = gap_length();
      end
    end
  end

  // Handshakes are sampled on the falling edge before the rising edge that completes them.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser, out_tlast);
  end

  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int sent;
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_APPEND;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, ignored opcode, byte extremes, short messages.
    send_item(OP_FLUSH, 8'hff);
    send_item(OP_IGNORED, 8'h55);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_APPEND, 8'hff);
    send_item(OP_IGNORED, 8'haa);
    send_item(OP_FINISH, 8'hff);
    send_item(OP_APPEND, 8'h80);
    send_item(OP_FLUSH, 8'h00);
    send_message(3, 1'b0);
    send_message(5, 1'b1);

    sent = 0;
    while (sent < 330) begin
      int len;
      case ($urandom_range(9))
        0: len = $urandom_range(58, 54);
        1: len = $urandom_range(66, 62);
        2: len = $urandom_range(130, 118);
        default: len = $urandom_range(12);
      endcase
      if ($urandom_range(9) == 0) send_item(OP_IGNORED, 8'($urandom));
      send_message(len, $urandom_range(1));
      sent += len + 1;
    end
    in_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
